// ===== sv/fr_pkg.sv =====
// Shared types, widths and constants of the filmic rational tone map unit.
package fr_pkg;

  // Fixed-point format of coefficients and pixels.
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned INT_BITS     = 8;
  localparam int unsigned OUT_INT_BITS = 4;

  localparam int unsigned WORD_W = INT_BITS + FRAC_BITS;       // Q8.16 word
  localparam int unsigned OUT_W  = OUT_INT_BITS + FRAC_BITS;   // Q4.16 result
  localparam int unsigned PROD_W = 2 * WORD_W - FRAC_BITS;     // word * word >> frac
  localparam int unsigned SUM_W  = PROD_W + 1;                 // product + product
  localparam int unsigned POLY_W = WORD_W + SUM_W - FRAC_BITS; // word * sum >> frac
  localparam int unsigned RAT_W  = POLY_W + 1;                 // numerator / denominator
  localparam int unsigned QUO_W  = RAT_W + FRAC_BITS;          // curve quotient

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // Register file.
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [2:0] {
    REG_SHOULDER   = 3'd0,
    REG_LIN_STR    = 3'd1,
    REG_LIN_ANGLE  = 3'd2,
    REG_TOE_STR    = 3'd3,
    REG_TOE_NUM    = 3'd4,
    REG_TOE_DEN    = 3'd5,
    REG_WHITE      = 3'd6,
    REG_EXPOSURE   = 3'd7
  } fr_reg_e;

  localparam logic [WORD_W-1:0] RST_SHOULDER  = 24'd9830;
  localparam logic [WORD_W-1:0] RST_LIN_STR   = 24'd32768;
  localparam logic [WORD_W-1:0] RST_LIN_ANGLE = 24'd6554;
  localparam logic [WORD_W-1:0] RST_TOE_STR   = 24'd13107;
  localparam logic [WORD_W-1:0] RST_TOE_NUM   = 24'd1311;
  localparam logic [WORD_W-1:0] RST_TOE_DEN   = 24'd19661;
  localparam logic [WORD_W-1:0] RST_WHITE     = 24'd734003;
  localparam logic [WORD_W-1:0] RST_EXPOSURE  = 24'd131072;

  typedef struct packed {
    logic [WORD_W-1:0] coef_shoulder_strength;
    logic [WORD_W-1:0] coef_linear_strength;
    logic [WORD_W-1:0] coef_linear_angle;
    logic [WORD_W-1:0] coef_toe_strength;
    logic [WORD_W-1:0] coef_toe_numerator;
    logic [WORD_W-1:0] coef_toe_denominator;
    logic [WORD_W-1:0] white_point;
    logic [WORD_W-1:0] exposure_gain;
  } fr_cfg_t;

  // Values derived from the registers alone.
  typedef struct packed {
    logic [PROD_W-1:0] cb;    // C*B
    logic [PROD_W-1:0] de;    // D*E
    logic [PROD_W-1:0] df;    // D*F
    logic [QUO_W-1:0]  eof;   // E/F
    logic [QUO_W-1:0]  fw;    // f(W)
    logic              bad;   // F or f(W) is zero
  } fr_const_t;

  typedef struct packed {
    logic [WORD_W-1:0] red_in;
    logic [WORD_W-1:0] green_in;
    logic [WORD_W-1:0] blue_in;
  } fr_pix_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
    logic             bad_config;
  } fr_pix_out_t;

  typedef enum logic [2:0] {
    PC_IDLE,
    PC_PROD,
    PC_ADD,
    PC_POLY,
    PC_SUM,
    PC_DIV_EOF,
    PC_DIV_FW,
    PC_FIN
  } fr_pc_state_e;

endpackage

// ===== sv/fr_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module fr_div_pipe #(
  parameter int unsigned NB  = 20,
  parameter int unsigned DW  = 58,
  parameter int unsigned SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [DW-1:0]  rem_i,
  input  logic [NB-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [SBW-1:0] sb_i,
  output logic           valid_o,
  output logic [NB-1:0]  quo_o,
  output logic [SBW-1:0] sb_o
);

  logic [NB-1:0]  v_q;
  logic [DW-1:0]  rem_q  [NB];
  logic [DW-1:0]  den_q  [NB];
  logic [NB-1:0]  bits_q [NB];
  logic [SBW-1:0] sb_q   [NB];

  logic [DW-1:0]  rem_in  [NB];
  logic [DW-1:0]  den_in  [NB];
  logic [NB-1:0]  bits_in [NB];
  logic [SBW-1:0] sb_in   [NB];
  logic [DW:0]    trial   [NB];
  logic [NB-1:0]  ge;
  logic [DW-1:0]  rem_d   [NB];
  logic [NB-1:0]  bits_d  [NB];

  always_comb begin
    rem_in[0]  = rem_i;
    den_in[0]  = den_i;
    bits_in[0] = num_i;
    sb_in[0]   = sb_i;
    for (int k = 1; k < NB; k++) begin
      rem_in[k]  = rem_q[k-1];
      den_in[k]  = den_q[k-1];
      bits_in[k] = bits_q[k-1];
      sb_in[k]   = sb_q[k-1];
    end
    // shift in the next dividend bit, subtract when it fits
    for (int k = 0; k < NB; k++) begin
      trial[k]  = {rem_in[k], bits_in[k][NB-1]};
      ge[k]     = (trial[k] >= {1'b0, den_in[k]});
      rem_d[k]  = ge[k] ? DW'(trial[k] - {1'b0, den_in[k]}) : trial[k][DW-1:0];
      bits_d[k] = {bits_in[k][NB-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NB-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NB; k++) begin
        rem_q[k]  <= rem_d[k];
        den_q[k]  <= den_in[k];
        bits_q[k] <= bits_d[k];
        sb_q[k]   <= sb_in[k];
      end
    end
  end

  assign valid_o = v_q[NB-1];
  assign quo_o   = bits_q[NB-1];
  assign sb_o    = sb_q[NB-1];

endmodule

// ===== sv/fr_lane.sv =====
// One color channel: exposure, rational curve, two pipelined divisions.
module fr_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [fr_pkg::WORD_W-1:0] chan_i,
  input  fr_pkg::fr_cfg_t           cfg_i,
  input  fr_pkg::fr_const_t         k_i,
  output logic                      valid_o,
  output logic [fr_pkg::OUT_W-1:0]  res_o
);

  localparam int unsigned WordW  = fr_pkg::WORD_W;
  localparam int unsigned FracW  = fr_pkg::FRAC_BITS;
  localparam int unsigned ProdW  = fr_pkg::PROD_W;
  localparam int unsigned SumW   = fr_pkg::SUM_W;
  localparam int unsigned PolyW  = fr_pkg::POLY_W;
  localparam int unsigned RatW   = fr_pkg::RAT_W;
  localparam int unsigned QuoW   = fr_pkg::QUO_W;
  localparam int unsigned OutW   = fr_pkg::OUT_W;
  localparam int unsigned OutSh  = fr_pkg::OUT_INT_BITS;

  logic [4:0] v_q;

  logic [WordW-1:0]       x1_q, x2_q, x3_q, x1_d;
  logic [2*WordW-1:0]     gx, ap;
  logic [ProdW-1:0]       ax_q, ax_d;
  logic [SumW-1:0]        t1_q, t2_q, t1_d, t2_d;
  logic [WordW+SumW-1:0]  pp1, pp2;
  logic [PolyW-1:0]       pn_q, pd_q;
  logic [RatW-1:0]        num_q, den_q, num_d, den_d;

  logic                   v6, dz6;
  logic [QuoW-1:0]        q6;
  logic                   vf_q;
  logic [QuoW-1:0]        f_q, f_d;
  logic                   sat_in, v7, sat7;
  logic [OutW-1:0]        q7;

  // exposure, saturate to the word range
  assign gx   = (2*WordW)'(chan_i) * (2*WordW)'(cfg_i.exposure_gain);
  assign x1_d = (|gx[2*WordW-1:WordW+FracW]) ? {WordW{1'b1}} : gx[WordW+FracW-1:FracW];

  assign ap   = (2*WordW)'(cfg_i.coef_shoulder_strength) * (2*WordW)'(x1_q);
  assign ax_d = ap[2*WordW-1:FracW];

  assign t1_d = {1'b0, ax_q} + {1'b0, k_i.cb};
  assign t2_d = {1'b0, ax_q} + SumW'(cfg_i.coef_linear_strength);

  assign pp1 = (WordW+SumW)'(x3_q) * (WordW+SumW)'(t1_q);
  assign pp2 = (WordW+SumW)'(x3_q) * (WordW+SumW)'(t2_q);

  assign num_d = {1'b0, pn_q} + RatW'(k_i.de);
  assign den_d = {1'b0, pd_q} + RatW'(k_i.df);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vf_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= {v_q[3:0], valid_i};
      vf_q <= v6;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q  <= x1_d;
      x2_q  <= x1_q;
      ax_q  <= ax_d;
      x3_q  <= x2_q;
      t1_q  <= t1_d;
      t2_q  <= t2_d;
      pn_q  <= pp1[WordW+SumW-1:FracW];
      pd_q  <= pp2[WordW+SumW-1:FracW];
      num_q <= num_d;
      den_q <= den_d;
      f_q   <= f_d;
    end
  end

  fr_div_pipe #(
    .NB  (QuoW),
    .DW  (RatW),
    .SBW (1)
  ) u_div_curve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v_q[4]),
    .rem_i   ('0),
    .num_i   ({num_q, {FracW{1'b0}}}),
    .den_i   (den_q),
    .sb_i    (den_q == '0),
    .valid_o (v6),
    .quo_o   (q6),
    .sb_o    (dz6)
  );

  // zero denominator gives zero; drop the toe offset, clamp at zero
  assign f_d = (dz6 || (q6 <= k_i.eof)) ? '0 : (q6 - k_i.eof);

  // quotient reaches the Q4.16 limit when f/16 >= f(W)
  assign sat_in = ((f_q >> OutSh) >= k_i.fw);

  fr_div_pipe #(
    .NB  (OutW),
    .DW  (QuoW),
    .SBW (1)
  ) u_div_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vf_q),
    .rem_i   (f_q >> OutSh),
    .num_i   ({f_q[OutSh-1:0], {FracW{1'b0}}}),
    .den_i   (k_i.fw),
    .sb_i    (sat_in),
    .valid_o (v7),
    .quo_o   (q7),
    .sb_o    (sat7)
  );

  assign valid_o = v7;
  assign res_o   = k_i.bad ? '0 : (sat7 ? fr_pkg::OUT_MAX : q7);

endmodule

// ===== sv/fr_precalc.sv =====
// Sequencer that derives f(W), E/F and the constant products from the registers.
module fr_precalc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fr_pkg::fr_cfg_t   cfg_i,
  output logic              busy_o,
  output fr_pkg::fr_const_t k_o
);

  localparam int unsigned WordW = fr_pkg::WORD_W;
  localparam int unsigned FracW = fr_pkg::FRAC_BITS;
  localparam int unsigned ProdW = fr_pkg::PROD_W;
  localparam int unsigned SumW  = fr_pkg::SUM_W;
  localparam int unsigned PolyW = fr_pkg::POLY_W;
  localparam int unsigned RatW  = fr_pkg::RAT_W;
  localparam int unsigned QuoW  = fr_pkg::QUO_W;
  localparam int unsigned CntW  = $clog2(QuoW);
  localparam logic [CntW-1:0] LastStep = CntW'(QuoW - 1);

  fr_pkg::fr_pc_state_e state_q, state_d;

  logic [ProdW-1:0]      cb_q, de_q, df_q, axw_q;
  logic [SumW-1:0]       t1_q, t2_q;
  logic [PolyW-1:0]      pn_q, pd_q;
  logic [RatW-1:0]       numw_q, denw_q;
  logic [RatW-1:0]       rem_q, dvs_q, rem_d;
  logic [QuoW-1:0]       bits_q, bits_d;
  logic [CntW-1:0]       cnt_q;
  logic [QuoW-1:0]       eof_q, fw_q, qv, fw_d;
  logic                  bad_q;
  logic [RatW:0]         trial;
  logic                  ge;
  logic [2*WordW-1:0]    pcb, pde, pdf, paw;
  logic [WordW+SumW-1:0] pp1, pp2;

  assign pcb = (2*WordW)'(cfg_i.coef_linear_angle) * (2*WordW)'(cfg_i.coef_linear_strength);
  assign pde = (2*WordW)'(cfg_i.coef_toe_strength) * (2*WordW)'(cfg_i.coef_toe_numerator);
  assign pdf = (2*WordW)'(cfg_i.coef_toe_strength) * (2*WordW)'(cfg_i.coef_toe_denominator);
  assign paw = (2*WordW)'(cfg_i.coef_shoulder_strength) * (2*WordW)'(cfg_i.white_point);
  assign pp1 = (WordW+SumW)'(cfg_i.white_point) * (WordW+SumW)'(t1_q);
  assign pp2 = (WordW+SumW)'(cfg_i.white_point) * (WordW+SumW)'(t2_q);

  // one restoring step per cycle
  assign trial  = {rem_q, bits_q[QuoW-1]};
  assign ge     = (trial >= {1'b0, dvs_q});
  assign rem_d  = ge ? RatW'(trial - {1'b0, dvs_q}) : trial[RatW-1:0];
  assign bits_d = {bits_q[QuoW-2:0], ge};

  assign qv   = (denw_q == '0) ? '0 : bits_q;
  assign fw_d = (qv > eof_q) ? (qv - eof_q) : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      fr_pkg::PC_IDLE:    state_d = fr_pkg::PC_IDLE;
      fr_pkg::PC_PROD:    state_d = fr_pkg::PC_ADD;
      fr_pkg::PC_ADD:     state_d = fr_pkg::PC_POLY;
      fr_pkg::PC_POLY:    state_d = fr_pkg::PC_SUM;
      fr_pkg::PC_SUM:     state_d = fr_pkg::PC_DIV_EOF;
      fr_pkg::PC_DIV_EOF: if (cnt_q == '0) state_d = fr_pkg::PC_DIV_FW;
      fr_pkg::PC_DIV_FW:  if (cnt_q == '0) state_d = fr_pkg::PC_FIN;
      fr_pkg::PC_FIN:     state_d = fr_pkg::PC_IDLE;
      default:            state_d = fr_pkg::PC_IDLE;
    endcase
    if (start_i) begin
      state_d = fr_pkg::PC_PROD;
    end
  end

  always_comb begin
    busy_o = (state_q != fr_pkg::PC_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fr_pkg::PC_PROD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      fr_pkg::PC_PROD: begin
        cb_q  <= pcb[2*WordW-1:FracW];
        de_q  <= pde[2*WordW-1:FracW];
        df_q  <= pdf[2*WordW-1:FracW];
        axw_q <= paw[2*WordW-1:FracW];
      end
      fr_pkg::PC_ADD: begin
        t1_q <= {1'b0, axw_q} + {1'b0, cb_q};
        t2_q <= {1'b0, axw_q} + SumW'(cfg_i.coef_linear_strength);
      end
      fr_pkg::PC_POLY: begin
        pn_q <= pp1[WordW+SumW-1:FracW];
        pd_q <= pp2[WordW+SumW-1:FracW];
      end
      fr_pkg::PC_SUM: begin
        numw_q <= {1'b0, pn_q} + RatW'(de_q);
        denw_q <= {1'b0, pd_q} + RatW'(df_q);
        // load E/F first
        rem_q  <= '0;
        bits_q <= QuoW'({cfg_i.coef_toe_numerator, {FracW{1'b0}}});
        dvs_q  <= RatW'(cfg_i.coef_toe_denominator);
        cnt_q  <= LastStep;
      end
      fr_pkg::PC_DIV_EOF: begin
        if (cnt_q == '0) begin
          eof_q  <= bits_d;
          rem_q  <= '0;
          bits_q <= {numw_q, {FracW{1'b0}}};
          dvs_q  <= denw_q;
          cnt_q  <= LastStep;
        end else begin
          rem_q  <= rem_d;
          bits_q <= bits_d;
          cnt_q  <= cnt_q - 1'b1;
        end
      end
      fr_pkg::PC_DIV_FW: begin
        rem_q  <= rem_d;
        bits_q <= bits_d;
        cnt_q  <= cnt_q - 1'b1;
      end
      fr_pkg::PC_FIN: begin
        fw_q  <= fw_d;
        bad_q <= (cfg_i.coef_toe_denominator == '0) || (fw_d == '0);
      end
      default: begin
      end
    endcase
  end

  assign k_o.cb  = cb_q;
  assign k_o.de  = de_q;
  assign k_o.df  = df_q;
  assign k_o.eof = eof_q;
  assign k_o.fw  = fw_q;
  assign k_o.bad = bad_q;

endmodule

// ===== sv/filmic_rational_tone_map_unit.sv =====
// Top level of the filmic rational tone map unit: registers, three lanes, output stage.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one linear RGB pixel,
//   each color unsigned Q8.16. Output channel (out_valid_o / out_stall_i / out_data_o)
//   returns the tone mapped color, unsigned Q4.16 saturating, plus bad_config.
//   A transfer happens on a rising edge with valid high and stall low.
//   Throughput is one pixel per clock while nothing stalls the input. The path holds 85
//   register stages: five exposure and polynomial stages, a 58-stage curve divider,
//   one subtract stage, a 20-stage normalizing divider and the output register.
//   The three colors run in parallel lanes that share one stall.
//   After reset and after every register write, a sequencer derives f(W), E/F and
//   the constant products; the input stalls while it runs.
//   When the receiver stalls while a pixel waits at the output, the output register
//   holds and the whole pipeline freezes with it; bubbles are kept, nothing is lost or repeated.
//   Registers sit on an APB-style port, one 32-bit word per register at 4*i; write
//   only while no pixel is in flight.
module filmic_rational_tone_map_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  fr_pkg::fr_pix_in_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output fr_pkg::fr_pix_out_t       out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fr_pkg::ADDR_W-1:0] paddr,
  input  logic [fr_pkg::DATA_W-1:0] pwdata,
  output logic [fr_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);

  localparam int unsigned WordW = fr_pkg::WORD_W;
  localparam int unsigned DataW = fr_pkg::DATA_W;
  localparam int unsigned OutW  = fr_pkg::OUT_W;

  fr_pkg::fr_cfg_t     cfg_q;
  fr_pkg::fr_const_t   kc;
  fr_pkg::fr_reg_e     reg_idx;
  fr_pkg::fr_pix_out_t out_q;
  logic                out_valid_q;
  logic                wr_en;
  logic                pc_busy;
  logic                advance;
  logic                in_acc;
  logic [WordW-1:0]    wval;
  logic [WordW-1:0]    rval;
  logic [2:0]          lane_valid;
  logic [OutW-1:0]     lane_res [3];

  // Register port: always ready, write on the access phase.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = fr_pkg::fr_reg_e'(paddr[fr_pkg::ADDR_W-1:2]);
  assign wval    = pwdata[WordW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_shoulder_strength <= fr_pkg::RST_SHOULDER;
      cfg_q.coef_linear_strength   <= fr_pkg::RST_LIN_STR;
      cfg_q.coef_linear_angle      <= fr_pkg::RST_LIN_ANGLE;
      cfg_q.coef_toe_strength      <= fr_pkg::RST_TOE_STR;
      cfg_q.coef_toe_numerator     <= fr_pkg::RST_TOE_NUM;
      cfg_q.coef_toe_denominator   <= fr_pkg::RST_TOE_DEN;
      cfg_q.white_point            <= fr_pkg::RST_WHITE;
      cfg_q.exposure_gain          <= fr_pkg::RST_EXPOSURE;
    end else if (wr_en) begin
      case (reg_idx)
        fr_pkg::REG_SHOULDER:  cfg_q.coef_shoulder_strength <= wval;
        fr_pkg::REG_LIN_STR:   cfg_q.coef_linear_strength   <= wval;
        fr_pkg::REG_LIN_ANGLE: cfg_q.coef_linear_angle      <= wval;
        fr_pkg::REG_TOE_STR:   cfg_q.coef_toe_strength      <= wval;
        fr_pkg::REG_TOE_NUM:   cfg_q.coef_toe_numerator     <= wval;
        fr_pkg::REG_TOE_DEN:   cfg_q.coef_toe_denominator   <= wval;
        fr_pkg::REG_WHITE:     cfg_q.white_point            <= wval;
        fr_pkg::REG_EXPOSURE:  cfg_q.exposure_gain          <= wval;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fr_pkg::REG_SHOULDER:  rval = cfg_q.coef_shoulder_strength;
      fr_pkg::REG_LIN_STR:   rval = cfg_q.coef_linear_strength;
      fr_pkg::REG_LIN_ANGLE: rval = cfg_q.coef_linear_angle;
      fr_pkg::REG_TOE_STR:   rval = cfg_q.coef_toe_strength;
      fr_pkg::REG_TOE_NUM:   rval = cfg_q.coef_toe_numerator;
      fr_pkg::REG_TOE_DEN:   rval = cfg_q.coef_toe_denominator;
      fr_pkg::REG_WHITE:     rval = cfg_q.white_point;
      fr_pkg::REG_EXPOSURE:  rval = cfg_q.exposure_gain;
      default:               rval = '0;
    endcase
  end

  assign prdata = DataW'(rval);

  // Restart the derived constants on every write.
  fr_precalc u_precalc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wr_en),
    .cfg_i   (cfg_q),
    .busy_o  (pc_busy),
    .k_o     (kc)
  );

  // Freeze the pipeline only while a finished pixel waits at the output.
  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !advance || pc_busy || wr_en;
  assign in_acc     = in_valid_i && !in_stall_o;

  fr_lane u_lane_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_acc),
    .chan_i  (in_data_i.red_in),
    .cfg_i   (cfg_q),
    .k_i     (kc),
    .valid_o (lane_valid[0]),
    .res_o   (lane_res[0])
  );

  fr_lane u_lane_green (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_acc),
    .chan_i  (in_data_i.green_in),
    .cfg_i   (cfg_q),
    .k_i     (kc),
    .valid_o (lane_valid[1]),
    .res_o   (lane_res[1])
  );

  fr_lane u_lane_blue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_acc),
    .chan_i  (in_data_i.blue_in),
    .cfg_i   (cfg_q),
    .k_i     (kc),
    .valid_o (lane_valid[2]),
    .res_o   (lane_res[2])
  );

  // Output register: load on advance, hold while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= lane_valid[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.red_out    <= lane_res[0];
      out_q.green_out  <= lane_res[1];
      out_q.blue_out   <= lane_res[2];
      out_q.bad_config <= kc.bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The three lanes must stay in lockstep.
  a_lanes_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_valid[0] == lane_valid[1]) && (lane_valid[0] == lane_valid[2]))
    else $error("color lanes out of step");

  // A register write always restarts the constant sequencer.
  a_write_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> pc_busy)
    else $error("write did not restart constant sequencer");

  // A bad configuration forces all colors to zero.
  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bad_config) |->
      (out_data_o.red_out == '0) && (out_data_o.green_out == '0) &&
      (out_data_o.blue_out == '0))
    else $error("bad_config with nonzero color");

endmodule
